@@ hdl/srwl_pkg.sv @@
// srwl_pkg: constants, types and state codes for the stereo RMS limiter.
// No dependencies.
package srwl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned MsW     = 40;
  localparam int unsigned HoldW   = 20;
  localparam int unsigned CeilW   = 23;
  localparam int unsigned GainW   = 24;
  localparam int unsigned CfgW    = 40;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [GainW-1:0] UnityGain = 24'd8388608;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegEnable    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDetCoef   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainCoef  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHold      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCeiling   = 3'd5;

  // sequencer states
  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StIdle   = 4'd0;
  localparam logic [StW-1:0] StSqL    = 4'd1;
  localparam logic [StW-1:0] StSqR    = 4'd2;
  localparam logic [StW-1:0] StDet    = 4'd3;
  localparam logic [StW-1:0] StHold   = 4'd4;
  localparam logic [StW-1:0] StSqrt   = 4'd5;
  localparam logic [StW-1:0] StDiv    = 4'd6;
  localparam logic [StW-1:0] StGain   = 4'd7;
  localparam logic [StW-1:0] StOutL   = 4'd8;
  localparam logic [StW-1:0] StOutR   = 4'd9;
  localparam logic [StW-1:0] StDone   = 4'd10;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_result;
    logic signed [SampleW-1:0] right_result;
    logic                      engaged;
    logic [GainW-1:0]          gain_now;
  } out_item_t;

endpackage

@@ hdl/srwl_stream_if.sv @@
// srwl_stream_if: valid/ready channel carrying one payload type.
// No dependencies; the payload type is a parameter.
interface srwl_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/stereo_rms_watchdog_limiter_unit.sv @@
// stereo_rms_watchdog_limiter_unit: RMS limiter with hold, one shared
// multiplier under a sequencer. Depends on srwl_pkg and srwl_stream_if.
// Per pair: square both samples, update the mean square and the hold;
// while the hold is engaged and the mean square nonzero, 24 square-root
// steps and 46 restoring divide steps; then gain glide and both outputs.
// Disabled pairs go straight to the output. The next pair is taken once the
// last result moves to the output register, which waits while it is full.
// Reset: config registers to defaults, mean square and hold zero, gain unity.
module stereo_rms_watchdog_limiter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srwl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srwl_pkg::CfgW-1:0]     cfg_data_i,
  srwl_stream_if.sink                   in_if,
  srwl_stream_if.source                 out_if
);

  logic                           enable_q;
  logic [srwl_pkg::CoefW-1:0]     det_coef_q, gain_coef_q;
  logic [srwl_pkg::MsW-1:0]       thresh_q;
  logic [srwl_pkg::HoldW-1:0]     hold_samples_q;
  logic [srwl_pkg::CeilW-1:0]     ceiling_q;

  logic [srwl_pkg::MsW-1:0]       ms_q, ms_d;
  logic [srwl_pkg::HoldW-1:0]     hold_q, hold_d;
  logic [srwl_pkg::GainW-1:0]     gain_q, gain_d;

  logic [srwl_pkg::StW-1:0]       st_q, st_d;
  logic [23:0]                    ma_q, mb_q;
  logic                           sa_q, sb_q;
  logic [48:0]                    acc_q, acc_d;      // pair power / scratch
  logic [srwl_pkg::GainW-1:0]     tgt_q, tgt_d;
  // square root: radicand ms<<8 = 48 bits, 24 iterations of 2 bits
  logic [47:0]                    rad_q, rad_d;
  logic [25:0]                    rem_q, rem_d;
  logic [23:0]                    root_q, root_d;
  logic [5:0]                     cnt_q, cnt_d;
  // divide: 46-bit dividend, quotient clamp fits in 24 bits
  logic [45:0]                    num_q, num_d;
  logic [24:0]                    drem_q, drem_d;
  logic [23:0]                    quo_q, quo_d;

  // result under construction, moved to the output register in StDone
  srwl_pkg::out_item_t            wrk_q, wrk_d;
  srwl_pkg::out_item_t            res_q, res_d;
  logic                           ovalid_q, ovalid_d;

  // shared multiplier, 40 x 24
  logic [39:0] mul_a;
  logic [23:0] mul_b;
  logic [63:0] mul_p;
  assign mul_p = {24'd0, mul_a} * {40'd0, mul_b};

  logic [39:0] ms_diff;
  logic        ms_up;
  logic [23:0] g_diff;
  logic        g_up;
  logic [25:0] sq_trial;
  logic [25:0] sq_rem_sh;
  logic [24:0] dv_sh;
  logic [47:0] out_r;

  always_comb begin
    ms_up   = acc_q[39:0] >= ms_q;
    ms_diff = ms_up ? acc_q[39:0] - ms_q : ms_q - acc_q[39:0];
    g_up    = tgt_q >= gain_q;
    g_diff  = g_up ? tgt_q - gain_q : gain_q - tgt_q;
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      srwl_pkg::StSqL: begin mul_a = {16'd0, ma_q}; mul_b = ma_q; end
      srwl_pkg::StSqR: begin mul_a = {16'd0, mb_q}; mul_b = mb_q; end
      srwl_pkg::StDet: begin mul_a = ms_diff; mul_b = det_coef_q; end
      srwl_pkg::StGain: begin mul_a = {16'd0, g_diff}; mul_b = gain_coef_q; end
      srwl_pkg::StOutL: begin mul_a = {16'd0, ma_q}; mul_b = gain_q; end
      srwl_pkg::StOutR: begin mul_a = {16'd0, mb_q}; mul_b = gain_q; end
      default: ;
    endcase
    sq_rem_sh = {rem_q[23:0], rad_q[47:46]};
    sq_trial  = {root_q, 2'b01};
    dv_sh     = {drem_q[23:0], num_q[45]};
    out_r     = mul_p[47:0] + 48'd4194304;
  end

  function automatic logic [23:0] sat_out(input logic neg, input logic [47:0] r);
    logic [24:0] m;
    m = r[47:23];
    if (neg) begin
      if (r[47:23] > 25'd8388608) m = 25'd8388608;
      sat_out = 24'(-m);
    end else begin
      if (r[47:23] > 25'd8388607) m = 25'd8388607;
      sat_out = m[23:0];
    end
  endfunction

  always_comb begin
    st_d = st_q; ms_d = ms_q; hold_d = hold_q; gain_d = gain_q;
    acc_d = acc_q; tgt_d = tgt_q; rad_d = rad_q; rem_d = rem_q;
    root_d = root_q; cnt_d = cnt_q; num_d = num_q; drem_d = drem_q;
    quo_d = quo_q; wrk_d = wrk_q; res_d = res_q; ovalid_d = ovalid_q;
    if (out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      srwl_pkg::StIdle: begin
        if (in_if.valid) begin
          if (!enable_q) begin
            ms_d = '0; hold_d = '0; gain_d = srwl_pkg::UnityGain;
            wrk_d.left_result  = in_if.data.left_in;
            wrk_d.right_result = in_if.data.right_in;
            wrk_d.engaged      = 1'b0;
            wrk_d.gain_now     = srwl_pkg::UnityGain;
            st_d = srwl_pkg::StDone;
          end else begin
            st_d = srwl_pkg::StSqL;
          end
        end
      end
      srwl_pkg::StSqL: begin acc_d = {1'b0, mul_p[47:0]}; st_d = srwl_pkg::StSqR; end
      srwl_pkg::StSqR: begin
        acc_d = {9'd0, 40'((acc_q + {1'b0, mul_p[47:0]}) >> 9)};
        st_d  = srwl_pkg::StDet;
      end
      srwl_pkg::StDet: begin
        ms_d = ms_up ? ms_q + mul_p[63:24] : ms_q - mul_p[63:24];
        st_d = srwl_pkg::StHold;
      end
      srwl_pkg::StHold: begin
        if (ms_q > thresh_q) hold_d = hold_samples_q;
        else if (hold_q != '0) hold_d = hold_q - 1'b1;
        tgt_d = srwl_pkg::UnityGain;
        rad_d = {ms_q, 8'd0}; rem_d = '0; root_d = '0; cnt_d = 6'd24;
        st_d = (hold_d != '0 && ms_q != '0) ? srwl_pkg::StSqrt : srwl_pkg::StGain;
      end
      srwl_pkg::StSqrt: begin
        rad_d = {rad_q[45:0], 2'b00};
        if (sq_rem_sh >= sq_trial) begin
          rem_d = sq_rem_sh - sq_trial; root_d = {root_q[22:0], 1'b1};
        end else begin
          rem_d = sq_rem_sh; root_d = {root_q[22:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          num_d = {ceiling_q, 23'd0}; drem_d = '0; quo_d = '0; cnt_d = 6'd46;
          st_d = srwl_pkg::StDiv;
        end
      end
      srwl_pkg::StDiv: begin
        num_d = {num_q[44:0], 1'b0};
        if (dv_sh >= {1'b0, root_q}) begin
          drem_d = dv_sh - {1'b0, root_q};
          quo_d  = (quo_q[23]) ? quo_q : {quo_q[22:0], 1'b1};
          if (quo_q[23]) quo_d = 24'hFFFFFF;
        end else begin
          drem_d = dv_sh;
          quo_d  = quo_q[23] ? 24'hFFFFFF : {quo_q[22:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          tgt_d = (quo_d < srwl_pkg::UnityGain) ? quo_d : srwl_pkg::UnityGain;
          st_d  = srwl_pkg::StGain;
        end
      end
      srwl_pkg::StGain: begin
        gain_d = g_up ? gain_q + mul_p[47:24] : gain_q - mul_p[47:24];
        if (gain_d > srwl_pkg::UnityGain) gain_d = srwl_pkg::UnityGain;
        st_d = srwl_pkg::StOutL;
      end
      srwl_pkg::StOutL: begin
        wrk_d.left_result = sat_out(sa_q, out_r);
        st_d = srwl_pkg::StOutR;
      end
      srwl_pkg::StOutR: begin
        wrk_d.right_result = sat_out(sb_q, out_r);
        wrk_d.engaged      = hold_q != '0;
        wrk_d.gain_now     = gain_q;
        st_d = srwl_pkg::StDone;
      end
      srwl_pkg::StDone: begin
        if (!ovalid_q || out_if.ready) begin
          res_d = wrk_q;
          ovalid_d = 1'b1; st_d = srwl_pkg::StIdle;
        end
      end
      default: st_d = srwl_pkg::StIdle;
    endcase
  end

  assign in_if.ready  = st_q == srwl_pkg::StIdle;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1; det_coef_q <= 24'd1398; gain_coef_q <= 24'd34917;
      thresh_q <= 40'd17098565454; hold_samples_q <= 20'd24000;
      ceiling_q <= 23'd1048576;
      ms_q <= '0; hold_q <= '0; gain_q <= srwl_pkg::UnityGain;
      st_q <= srwl_pkg::StIdle; ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srwl_pkg::RegEnable:    enable_q       <= cfg_data_i[0];
          srwl_pkg::RegDetCoef:   det_coef_q     <= cfg_data_i[23:0];
          srwl_pkg::RegGainCoef:  gain_coef_q    <= cfg_data_i[23:0];
          srwl_pkg::RegThreshold: thresh_q       <= cfg_data_i;
          srwl_pkg::RegHold:      hold_samples_q <= cfg_data_i[19:0];
          srwl_pkg::RegCeiling:   ceiling_q      <= cfg_data_i[22:0];
          default: ;
        endcase
      end
      ms_q <= ms_d; hold_q <= hold_d; gain_q <= gain_d;
      st_q <= st_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sa_q <= in_if.data.left_in[23];
      sb_q <= in_if.data.right_in[23];
      ma_q <= in_if.data.left_in[23] ? 24'(-in_if.data.left_in) : in_if.data.left_in;
      mb_q <= in_if.data.right_in[23] ? 24'(-in_if.data.right_in) : in_if.data.right_in;
    end
    acc_q <= acc_d; tgt_q <= tgt_d; rad_q <= rad_d; rem_q <= rem_d;
    root_q <= root_d; cnt_q <= cnt_d; num_q <= num_d; drem_q <= drem_d;
    quo_q <= quo_d; wrk_q <= wrk_d; res_q <= res_d;
  end

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for stereo_rms_watchdog_limiter_unit.
// Drives sample pairs with random idling and checks every result against
// a bit-exact predictor. Depends on srwl_pkg and srwl_stream_if.
`timescale 1ns / 100ps

module tb;

  localparam logic [srwl_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [srwl_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [srwl_pkg::CfgW-1:0] cfg_data_i = '0;

  srwl_stream_if #(.payload_t(srwl_pkg::in_item_t)) in_if ();
  srwl_stream_if #(.payload_t(srwl_pkg::out_item_t)) out_if ();

  stereo_rms_watchdog_limiter_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // limiter settings and state as seen by the predictor
  logic        lim_en;
  logic [23:0] det_k, gain_k;
  logic [39:0] trip_ms;
  logic [19:0] hold_len;
  logic [22:0] ceil_amp;
  logic [39:0] ms_acc;
  logic [19:0] hold_cnt;
  logic [23:0] cur_gain;

  srwl_pkg::in_item_t  pair_q[$];
  srwl_pkg::out_item_t limited_q[$];
  int errors = 0;
  int send_idle = 27, recv_idle = 66;
  bit recv_hold = 1'b0;
  bit stall_go = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] glide(logic [63:0] cur, logic [63:0] tgt, logic [23:0] k);
    if (tgt >= cur) return cur + (((tgt - cur) * k) >> 24);
    return cur - (((cur - tgt) * k) >> 24);
  endfunction

  function automatic logic [23:0] apply_gain(logic signed [23:0] x, logic [23:0] g);
    logic [63:0] mag, r;
    mag = x < 0 ? 64'(-64'(x)) : 64'(x);
    r = (mag * g + (64'd1 << 22)) >> 23;
    if (x < 0) begin
      if (r > 8388608) r = 8388608;
      return 24'(-r);
    end
    if (r > 8388607) r = 8388607;
    return r[23:0];
  endfunction

  function automatic srwl_pkg::out_item_t limit_pair(srwl_pkg::in_item_t it);
    srwl_pkg::out_item_t o;
    logic [63:0] ma, mb, pw, tgt, q;
    if (!lim_en) begin
      ms_acc = 0; hold_cnt = 0; cur_gain = srwl_pkg::UnityGain;
      o.left_result = it.left_in; o.right_result = it.right_in;
      o.engaged = 1'b0; o.gain_now = srwl_pkg::UnityGain;
      return o;
    end
    ma = it.left_in < 0 ? 64'(-64'(it.left_in)) : 64'(it.left_in);
    mb = it.right_in < 0 ? 64'(-64'(it.right_in)) : 64'(it.right_in);
    pw = (ma * ma + mb * mb) >> 9;
    ms_acc = 40'(glide(64'(ms_acc), pw, det_k));
    if (ms_acc > trip_ms) hold_cnt = hold_len;
    else if (hold_cnt > 0) hold_cnt--;
    tgt = 64'(srwl_pkg::UnityGain);
    if (hold_cnt > 0 && ms_acc > 0) begin
      q = (64'(ceil_amp) << 23) / root64(64'(ms_acc) << 8);
      if (q < tgt) tgt = q;
    end
    q = glide(64'(cur_gain), tgt, gain_k);
    cur_gain = q > 64'(srwl_pkg::UnityGain) ? srwl_pkg::UnityGain : q[23:0];
    o.left_result = apply_gain(it.left_in, cur_gain);
    o.right_result = apply_gain(it.right_in, cur_gain);
    o.engaged = hold_cnt > 0;
    o.gain_now = cur_gain;
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid && in_if.ready) limited_q.push_back(limit_pair(in_if.data));
      if (pair_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid <= 1'b1;
        in_if.data <= pair_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (limited_q.size() == 0) begin
          $error("unexpected transaction %h", out_if.data);
          errors++;
        end else begin
          srwl_pkg::out_item_t e;
          e = limited_q.pop_front();
          if (out_if.data.left_result !== e.left_result) begin
            $error("left_result exp %0d got %0d", e.left_result, out_if.data.left_result);
            errors++;
          end
          if (out_if.data.right_result !== e.right_result) begin
            $error("right_result exp %0d got %0d", e.right_result, out_if.data.right_result);
            errors++;
          end
          if (out_if.data.engaged !== e.engaged) begin
            $error("engaged exp %0d got %0d", e.engaged, out_if.data.engaged);
            errors++;
          end
          if (out_if.data.gain_now !== e.gain_now) begin
            $error("gain_now exp %0d got %0d", e.gain_now, out_if.data.gain_now);
            errors++;
          end
        end
      end
      out_if.ready <= !recv_hold && $urandom_range(99) >= recv_idle;
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (stall_go);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  task automatic write_reg(logic [srwl_pkg::CfgIdxW-1:0] idx, logic [srwl_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      srwl_pkg::RegEnable:    lim_en = val[0];
      srwl_pkg::RegDetCoef:   det_k = val[23:0];
      srwl_pkg::RegGainCoef:  gain_k = val[23:0];
      srwl_pkg::RegThreshold: trip_ms = val[39:0];
      srwl_pkg::RegHold:      hold_len = val[19:0];
      srwl_pkg::RegCeiling:   ceil_amp = val[22:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || in_if.valid || limited_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic push_pair(logic [23:0] l, logic [23:0] r);
    srwl_pkg::in_item_t it;
    it.left_in = l;
    it.right_in = r;
    pair_q.push_back(it);
  endtask

  // loud bursts trip the detector; quiet stretches let the hold expire
  task automatic random_pairs(int n);
    int loud;
    logic [23:0] amp;
    loud = 0;
    for (int i = 0; i < n; i++) begin
      if (loud == 0 && $urandom_range(19) == 0) loud = $urandom_range(60, 5);
      if ($urandom_range(9) == 0) amp = 24'h7FFFFF;
      else amp = loud > 0 ? 24'($urandom_range(8388607, 2000000)) : 24'($urandom_range(300000));
      if (loud > 0) loud--;
      push_pair($urandom_range(1) ? amp : -amp, $urandom_range(1) ? 24'($urandom) : -amp);
    end
  endtask

  initial begin
    lim_en = 1; det_k = 1398; gain_k = 34917; trip_ms = 40'd17098565454;
    hold_len = 24000; ceil_amp = 1048576;
    ms_acc = 0; hold_cnt = 0; cur_gain = srwl_pkg::UnityGain;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fast detector and gain so the directed pairs reach the engaged state
    write_reg(srwl_pkg::RegDetCoef, 40'h800000);
    write_reg(srwl_pkg::RegGainCoef, 40'hFFFFFF);
    write_reg(srwl_pkg::RegHold, 40'd5);
    write_reg(srwl_pkg::RegThreshold, 40'd1 << 30);
    push_pair(24'h7FFFFF, 24'h7FFFFF);
    push_pair(24'h800000, 24'h800000);
    push_pair(24'h800000, 24'h7FFFFF);
    push_pair(24'h000000, 24'h000000);
    push_pair(24'h000001, 24'hFFFFFF);
    push_pair(24'hAAAAAA, 24'h555555);
    push_pair(24'h555555, 24'hAAAAAA);
    for (int i = 0; i < 8; i++) push_pair(24'h0, 24'h0);
    drain();
    write_reg(srwl_pkg::RegHold, 40'd0);       // never engages
    push_pair(24'h7FFFFF, 24'h800000);
    push_pair(24'h800000, 24'h7FFFFF);
    drain();
    write_reg(srwl_pkg::RegEnable, 40'h2);     // bit 0 clear: bypass
    push_pair(24'h800000, 24'h7FFFFF);
    push_pair(24'h123456, 24'hFEDCBA);
    drain();
    write_reg(RegUnused, 40'hFFFFFFFFFF);
    write_reg(srwl_pkg::RegEnable, 40'h1);
    write_reg(srwl_pkg::RegDetCoef, 40'd0);    // detector frozen
    write_reg(srwl_pkg::RegHold, 40'hFFFFF);
    write_reg(srwl_pkg::RegCeiling, 40'h7FFFFF);
    push_pair(24'h7FFFFF, 24'h7FFFFF);
    push_pair(24'h400000, 24'hC00000);
    drain();

    // receiver idles more, with a long hold-off that stalls the limiter
    write_reg(srwl_pkg::RegDetCoef, 40'h040000);
    write_reg(srwl_pkg::RegGainCoef, 40'h100000);
    write_reg(srwl_pkg::RegThreshold, 40'd4000000000);
    write_reg(srwl_pkg::RegHold, 40'd40);
    write_reg(srwl_pkg::RegCeiling, 40'd600000);
    random_pairs(300);
    stall_go = 1'b1;
    random_pairs(300);
    drain();

    send_idle = 66; recv_idle = 27;
    write_reg(srwl_pkg::RegThreshold, 40'hFFFFFFFFFF);
    write_reg(srwl_pkg::RegGainCoef, 40'd0);
    random_pairs(150);
    drain();
    write_reg(srwl_pkg::RegThreshold, 40'd0);
    write_reg(srwl_pkg::RegGainCoef, 40'hFFFFFF);
    write_reg(srwl_pkg::RegDetCoef, 40'hFFFFFF);
    write_reg(srwl_pkg::RegCeiling, 40'd0);
    write_reg(srwl_pkg::RegHold, 40'd3);
    random_pairs(300);
    drain();

    send_idle = 0; recv_idle = 0;
    write_reg(srwl_pkg::RegCeiling, 40'd1048576);
    write_reg(srwl_pkg::RegDetCoef, 40'd1398);
    write_reg(srwl_pkg::RegGainCoef, 40'd34917);
    write_reg(srwl_pkg::RegThreshold, 40'd17098565454);
    write_reg(srwl_pkg::RegHold, 40'd200);
    random_pairs(400);
    drain();
    write_reg(srwl_pkg::RegEnable, 40'h0);
    random_pairs(100);
    drain();
    write_reg(srwl_pkg::RegEnable, 40'h1);
    write_reg(srwl_pkg::RegDetCoef, 40'h200000);
    random_pairs(300);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ stereo_rms_watchdog_limiter_unit.f @@
hdl/srwl_pkg.sv
hdl/srwl_stream_if.sv
hdl/stereo_rms_watchdog_limiter_unit.sv
tb/tb.sv
